// ===== sv/lcgr_pkg.sv =====
`default_nettype none

package lcgr_pkg;

    // Request codes
    localparam logic [1:0] REQ_UNSIGNED = 2'd0;
    localparam logic [1:0] REQ_SIGNED   = 2'd1;
    localparam logic [1:0] REQ_RESTART  = 2'd2;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned DIV_STEPS = WORD_W;
    localparam int unsigned CNT_W    = $clog2(DIV_STEPS);

    localparam logic [WORD_W-1:0] LCG_MULT   = 32'd10807;
    localparam logic [WORD_W-1:0] LCG_INCR   = 32'd1;
    localparam logic [WORD_W-1:0] SEED_RESET = 32'd1;
    localparam logic [WORD_W-1:0] SIGN_FLIP  = 32'h8000_0000;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [WORD_W-1:0] low_bound;
        logic [WORD_W-1:0] high_bound;
    } t_req;

    typedef struct packed {
        logic [WORD_W-1:0] value;
        logic              range_error;
    } t_res;

    // Controller to datapath
    typedef struct packed {
        logic load;      // latch request fields
        logic advance;   // step generator word and seed the divider
        logic div_step;  // one restoring-division step
        logic out_load;  // write the result register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic draw_ok;   // latched request is a draw with a non-empty range
        logic out_free;  // result register can take a new transaction
    } t_status;

endpackage

`default_nettype wire

// ===== sv/lcgr_ctrl.sv =====
`default_nettype none

module lcgr_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    input  wire lcgr_pkg::t_status i_status,
    output lcgr_pkg::t_cmd       o_cmd
);
    import lcgr_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_ADV  = 4'b0010,
        S_DIV  = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              w_last;

    assign w_last     = (r_cnt == CNT_W'(DIV_STEPS - 1));
    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_ADV;
                end
            end
            S_ADV: begin
                if (i_status.draw_ok) begin
                    o_cmd.advance = 1'b1;
                    n_cnt         = '0;
                    n_state       = S_DIV;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + CNT_W'(1);
                if (w_last) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    a_out_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_status.out_free)
        else $error("result written while result register still occupied");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_ADV))
        else $error("accepted transaction did not start processing");

    a_cnt_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_DIV) |-> (r_cnt == '0))
        else $error("step counter not cleared outside division");

endmodule

`default_nettype wire

// ===== sv/lcgr_dpath.sv =====
`default_nettype none

module lcgr_dpath (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [31:0]       i_cfg_wdata,
    input  wire lcgr_pkg::t_req    i_req,
    input  wire lcgr_pkg::t_cmd    i_cmd,
    output lcgr_pkg::t_status      o_status,
    input  wire logic              i_out_stall,
    output logic                   o_out_valid,
    output lcgr_pkg::t_res         o_out_data
);
    import lcgr_pkg::*;

    logic [WORD_W-1:0] r_seed, r_word, r_lo, r_span, r_dvd, r_rem;
    logic              r_err, r_draw_ok, r_out_valid;
    t_res              r_out_data;

    logic              w_is_draw, w_signed, w_ok;
    logic [WORD_W-1:0] w_next_word;
    logic [WORD_W:0]   w_shift, w_diff;
    logic [WORD_W-1:0] w_rem_next;

    assign w_is_draw = (i_req.req_type == REQ_UNSIGNED) || (i_req.req_type == REQ_SIGNED);
    assign w_signed  = (i_req.req_type == REQ_SIGNED);
    assign w_ok = w_signed ? ((i_req.high_bound ^ SIGN_FLIP) > (i_req.low_bound ^ SIGN_FLIP))
                           : (i_req.high_bound > i_req.low_bound);

    assign w_next_word = r_word * LCG_MULT + LCG_INCR;

    assign w_shift    = {r_rem, r_dvd[WORD_W-1]};
    assign w_diff     = w_shift - {1'b0, r_span};
    assign w_rem_next = w_diff[WORD_W] ? w_shift[WORD_W-1:0] : w_diff[WORD_W-1:0];

    assign o_status.draw_ok  = r_draw_ok;
    assign o_status.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed      <= SEED_RESET;
            r_word      <= SEED_RESET;
            r_err       <= 1'b0;
            r_draw_ok   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_seed <= i_cfg_wdata;
                r_word <= i_cfg_wdata;
            end else if (i_cmd.load && (i_req.req_type == REQ_RESTART)) begin
                r_word <= r_seed;
            end else if (i_cmd.advance) begin
                r_word <= w_next_word;
            end

            if (i_cmd.load) begin
                r_err     <= w_is_draw && !w_ok;
                r_draw_ok <= w_is_draw && w_ok;
            end

            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_lo   <= i_req.low_bound;
            r_span <= i_req.high_bound - i_req.low_bound;
        end
        if (i_cmd.advance) begin
            r_dvd <= w_next_word;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_dvd <= {r_dvd[WORD_W-2:0], 1'b0};
            r_rem <= w_rem_next;
        end
        if (i_cmd.out_load) begin
            r_out_data.value       <= r_draw_ok ? (r_lo + r_rem) : '0;
            r_out_data.range_error <= r_err;
        end
    end

    a_rem_below_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_rem < r_span))
        else $error("partial remainder reached the span");

    a_error_gives_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.out_load && r_err) |=> (o_out_data.value == '0) && o_out_data.range_error)
        else $error("range error result not zero");

    a_restart_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load && (i_req.req_type == REQ_RESTART) && !i_cfg_we)
        |=> (r_word == $past(r_seed)))
        else $error("restart did not reload generator word");

endmodule

`default_nettype wire

// ===== sv/lcg_range_random_top.sv =====
`default_nettype none

// Channel  | Direction | Valid       | Stall        | Payload
// request  | in        | i_in_valid  | o_in_stall   | i_in_data  (t_req)
// result   | out       | o_out_valid | i_out_stall  | o_out_data (t_res)
// seed     | in        | i_cfg_we    | (none)       | i_cfg_wdata
//
// A draw latches its request on the accepting edge, then steps the generator word,
// runs the bit-per-cycle restoring divider and adds the lower bound into the result
// register. The next request is accepted only once that result has been written.
// Restart, empty ranges and unused codes skip the generator step and the divider.
// Reset loads seed and generator word with 1 and empties the result register.
// A waiting result does not block acceptance; only the final write waits on it,
// for as long as the held result stays stalled.

module lcg_range_random_top (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    input  wire lcgr_pkg::t_req  i_in_data,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    output lcgr_pkg::t_res       o_out_data,
    input  wire logic            i_cfg_we,
    input  wire logic [31:0]     i_cfg_wdata
);
    import lcgr_pkg::*;

    // command and status between sequencer and datapath
    t_cmd    w_cmd;
    t_status w_status;

    // sequencer: accept, advance, divide, write back
    lcgr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // datapath: seed, generator word, divider and result register
    lcgr_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (i_in_data),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

// ===== sim/lcg_range_random_top_test.sv =====
`timescale 1ns / 100ps

module lcg_range_random_top_test;
    import lcgr_pkg::*;

    // The package names three request codes; the fourth must be ignored by the block.
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // Allow a tail past the last expected result before stopping.
    localparam int DRAIN_TAIL  = 40;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int RANDOM_PER_PHASE = 222;
    localparam int N_PHASES = 7;

    typedef struct packed {
        t_req req;
        logic typed;     // 1: expectation below is literal, 0: use the draw predictor
        t_res res;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_req        i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_res        o_out_data;
    logic        i_cfg_we = 1'b0;
    logic [31:0] i_cfg_wdata = '0;

    // Predictor state: seed register and generator word as the block should hold them.
    logic [31:0] model_seed = SEED_RESET;
    logic [31:0] model_word = SEED_RESET;

    // Results owed by the block, oldest first.
    t_res expected_results[$];

    // While set, the sender inserts no gaps and the receiver starts no new stall bursts.
    bit calm_stretch = 1'b0;

    int cycle_count    = 0;
    int mismatch_count = 0;
    int results_seen   = 0;
    int draws_sent     = 0;
    int empty_sent     = 0;
    int other_sent     = 0;
    int seeds_written  = 0;

    lcg_range_random_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Hard stop in case the block hangs on a handshake.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Gap length: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int sel;
        sel = $urandom_range(0, 99);
        if (calm_stretch || sel < 55)
            return 0;
        else if (sel < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 40);
    endfunction

    // Advance the predictor by one request transaction and return the result it owes.
    function automatic t_res predict_result(input t_req r);
        t_res        res;
        logic [31:0] span;
        logic        ordered;
        res = '0;
        case (r.req_type)
            REQ_UNSIGNED, REQ_SIGNED: begin
                // Flip sign bits so an unsigned compare orders two's complement bounds.
                if (r.req_type == REQ_SIGNED)
                    ordered = (r.high_bound ^ SIGN_FLIP) > (r.low_bound ^ SIGN_FLIP);
                else
                    ordered = r.high_bound > r.low_bound;
                if (ordered) begin
                    span = r.high_bound - r.low_bound;
                    model_word = model_word * LCG_MULT + LCG_INCR;
                    res.value = r.low_bound + (model_word % span);
                end else begin
                    // Empty range: flag it, leave the generator word alone.
                    res.range_error = 1'b1;
                end
            end
            REQ_RESTART: model_word = model_seed;
            default: ;
        endcase
        return res;
    endfunction

    function automatic t_dir_row dir_row(input logic [1:0] kind, input logic [31:0] lo,
                                         input logic [31:0] hi, input logic typed,
                                         input logic [31:0] val, input logic err);
        t_dir_row row;
        row.req.req_type   = kind;
        row.req.low_bound  = lo;
        row.req.high_bound = hi;
        row.typed          = typed;
        row.res.value      = val;
        row.res.range_error = err;
        return row;
    endfunction

    // Nonzero span: tiny, power of two, arbitrary or close to the full word.
    function automatic logic [31:0] pick_span();
        int          sel;
        logic [31:0] span;
        sel = $urandom_range(0, 99);
        if (sel < 20)
            span = $urandom_range(1, 16);
        else if (sel < 35)
            span = 32'd1 << $urandom_range(0, 31);
        else if (sel < 85)
            span = $urandom;
        else
            span = 32'hFFFF_FFFF - $urandom_range(0, 15);
        if (span == 32'd0)
            span = 32'd1;
        return span;
    endfunction

    // Mostly well-formed draws with random bounds; the rest empty ranges, restarts,
    // unused codes and raw noise.
    function automatic t_req make_request();
        t_req        r;
        int          sel;
        logic [31:0] span;
        logic [31:0] lo_off;
        logic [31:0] hi_off;
        logic [31:0] flip;
        sel = $urandom_range(0, 99);
        r.req_type   = ($urandom_range(0, 1) == 0) ? REQ_UNSIGNED : REQ_SIGNED;
        // Work in offset space; XOR with the sign bit maps it to signed bounds.
        flip = (r.req_type == REQ_SIGNED) ? SIGN_FLIP : 32'd0;
        if (sel < 75) begin
            span   = pick_span();
            lo_off = $urandom_range(0, 32'hFFFF_FFFF - span);
            hi_off = lo_off + span;
        end else if (sel < 85) begin
            lo_off = $urandom;
            hi_off = ($urandom_range(0, 3) == 0) ? lo_off : $urandom_range(0, lo_off);
        end else begin
            lo_off = $urandom;
            hi_off = $urandom;
            flip   = 32'd0;
            if (sel < 93)
                r.req_type = REQ_RESTART;
            else if (sel < 97)
                r.req_type = REQ_UNUSED;
            else
                r.req_type = 2'($urandom_range(0, 3));
        end
        r.low_bound  = lo_off ^ flip;
        r.high_bound = hi_off ^ flip;
        return r;
    endfunction

    // Present one request transaction, hold it until accepted, then record what it owes.
    task automatic push_request(input t_req r, input logic typed, input t_res typed_res);
        int   gap;
        t_res predicted;
        if ($urandom_range(0, 99) < 2)
            calm_stretch = !calm_stretch;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= r;
        do @(posedge i_clk); while (o_in_stall);
        predicted = predict_result(r);
        expected_results.push_back(typed ? typed_res : predicted);
        if (predicted.range_error)
            empty_sent++;
        else if (r.req_type == REQ_UNSIGNED || r.req_type == REQ_SIGNED)
            draws_sent++;
        else
            other_sent++;
    endtask

    // Drop valid, then wait until every owed result has come back plus a tail.
    task automatic drain_results(input int tail);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (tail) @(posedge i_clk);
    endtask

    // Write the seed while idle; the generator word reloads with it.
    task automatic write_seed(input logic [31:0] seed);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= seed;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        model_seed = seed;
        model_word = seed;
        seeds_written++;
    endtask

    // Receiver: stall in bursts of random length, never during reset.
    int stall_left = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else begin
            i_out_stall <= 1'b0;
            if ($urandom_range(0, 99) < 30)
                stall_left = pick_gap();
        end
    end

    // Check each accepted result against the oldest expectation, field by field.
    always @(posedge i_clk) begin : result_check
        t_res want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                $display("%0t: result with nothing owed: value=%h range_error=%b",
                         $time, o_out_data.value, o_out_data.range_error);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                if (o_out_data.value !== want.value) begin
                    $display("%0t: value expected %h actual %h",
                             $time, want.value, o_out_data.value);
                    mismatch_count++;
                end
                if (o_out_data.range_error !== want.range_error) begin
                    $display("%0t: range_error expected %b actual %b",
                             $time, want.range_error, o_out_data.range_error);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin : stimulus
        t_dir_row    directed_rows [22];
        logic [31:0] phase_seeds [N_PHASES];

        // Rows after reset with seed 1; literal expectations only where obvious.
        directed_rows = '{
            dir_row(REQ_UNSIGNED, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 32'd10808, 1'b0),
            dir_row(REQ_UNSIGNED, 32'h0000_0005, 32'h0000_0005, 1'b1, 32'd0, 1'b1),
            dir_row(REQ_UNSIGNED, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'd0, 1'b1),
            dir_row(REQ_SIGNED,   32'h0000_0000, 32'h8000_0000, 1'b1, 32'd0, 1'b1),
            dir_row(REQ_SIGNED,   32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 32'd0, 1'b1),
            dir_row(REQ_UNSIGNED, 32'h0000_0007, 32'h0000_0008, 1'b1, 32'd7, 1'b0),
            dir_row(REQ_SIGNED,   32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF, 1'b0),
            dir_row(REQ_SIGNED,   32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 32'd0, 1'b0),
            dir_row(REQ_UNSIGNED, 32'h0000_0000, 32'h0000_0001, 1'b1, 32'd0, 1'b0),
            dir_row(REQ_UNSIGNED, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFE, 1'b0),
            dir_row(REQ_RESTART,  32'h0000_0000, 32'h0000_0000, 1'b1, 32'd0, 1'b0),
            // back at seed 1, so the first draw repeats
            dir_row(REQ_UNSIGNED, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 32'd10808, 1'b0),
            dir_row(REQ_UNUSED,   32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'd0, 1'b0),
            dir_row(REQ_UNUSED,   32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 32'd0, 1'b0),
            dir_row(REQ_UNSIGNED, 32'h0000_0000, 32'h0000_000A, 1'b0, 32'd0, 1'b0),
            dir_row(REQ_SIGNED,   32'h8000_0000, 32'h8000_0001, 1'b1, 32'h8000_0000, 1'b0),
            dir_row(REQ_SIGNED,   32'hFFFF_FFF0, 32'h0000_0010, 1'b0, 32'd0, 1'b0),
            dir_row(REQ_UNSIGNED, 32'h1234_5678, 32'h9ABC_DEF0, 1'b0, 32'd0, 1'b0),
            dir_row(REQ_RESTART,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'd0, 1'b0),
            dir_row(REQ_SIGNED,   32'h7FFF_FFFE, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFE, 1'b0),
            dir_row(REQ_UNSIGNED, 32'h0000_0000, 32'h8000_0000, 1'b0, 32'd0, 1'b0),
            dir_row(REQ_SIGNED,   32'h0000_0000, 32'h7FFF_FFFF, 1'b0, 32'd0, 1'b0)
        };

        // Seed extremes first, then random words, and finally back to the reset value.
        phase_seeds[0] = 32'h0000_0000;
        phase_seeds[1] = 32'hFFFF_FFFF;
        phase_seeds[2] = 32'h8000_0000;
        for (int i = 3; i < N_PHASES - 1; i++)
            phase_seeds[i] = $urandom;
        phase_seeds[N_PHASES-1] = SEED_RESET;

        // Hold reset, then release it away from the rising edge.
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i])
            push_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].res);
        drain_results(4);

        // Each phase: reseed while idle, then a batch of random transactions.
        for (int p = 0; p < N_PHASES; p++) begin
            write_seed(phase_seeds[p]);
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
                push_request(make_request(), 1'b0, '0);
            drain_results(4);
        end

        drain_results(DRAIN_TAIL);

        $display("Sent %0d draws, %0d empty ranges, %0d restarts or unused codes",
                 draws_sent, empty_sent, other_sent);
        $display("Checked %0d results across %0d seed writes, %0d mismatches",
                 results_seen, seeds_written, mismatch_count);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
